// File: src/psb_pkg.sv
// Shared constants, types and helpers for the particle sphere bounce step block.
// Used by psb_collide and particle_sphere_bounce_euler_step_top; no dependencies.
`default_nettype none

package psb_pkg;

    localparam int SPHERE_COUNT = 3;
    localparam int SPHERE_REGS  = 3;
    localparam int NUM_SPHERES  = (SPHERE_COUNT < SPHERE_REGS) ? SPHERE_COUNT : SPHERE_REGS;

    // Quotient bits of the velocity correction, after the Q16 shift.
    localparam int QUOT_W  = 35;
    localparam int NUM_W   = 98;
    localparam int COL_LAT = 6 + QUOT_W + 1;

    // Configuration register indexes.
    localparam logic [2:0] REG_SPHERE_A = 3'd0;
    localparam logic [2:0] REG_SPHERE_B = 3'd1;
    localparam logic [2:0] REG_SPHERE_C = 3'd2;
    localparam logic [2:0] REG_TIME_STEP = 3'd3;
    localparam logic [2:0] REG_GRAVITY_Y = 3'd4;
    localparam logic [2:0] REG_BOUNCE   = 3'd5;

    localparam logic [63:0] SPHERE_A_RST = 64'h0000_0C00_0100_0300;
    localparam logic [63:0] SPHERE_B_RST = 64'hFD00_0000_0000_0700;
    localparam logic [63:0] SPHERE_C_RST = 64'h0500_F600_0000_0C00;
    localparam logic [15:0] TIME_STEP_RST = 16'd1092;
    localparam logic [31:0] GRAVITY_Y_RST = 32'hFFF6_30A4;
    localparam logic [17:0] BOUNCE_RST    = 18'd78643;

    localparam logic signed [31:0] FLOOR_Y  = -32'sd1966080;
    localparam logic signed [31:0] SPAWN_Y  = 32'sd1310720;
    localparam logic signed [19:0] HALF_Q16 = 20'sd32768;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
    } particle_t;

    function automatic logic [31:0] sat32(input logic signed [39:0] v);
        logic [31:0] r;
        if (v > 40'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -40'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/psb_collide.sv
// One sphere collision unit: distance test, dot product and a pipelined
// restoring divider for the velocity correction. Depends on psb_pkg.
`default_nettype none

module psb_collide (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 ce,
    input  wire logic                 in_valid,
    input  wire psb_pkg::particle_t   in_part,
    input  wire logic [63:0]          sphere,
    input  wire logic [17:0]          bounce,
    output logic                      out_valid,
    output psb_pkg::particle_t        out_part
);

    // ---------------- stage 1: offsets and box test ----------------
    logic signed [23:0] cen [3];
    logic signed [23:0] rq;
    logic signed [32:0] d_full [3];
    logic [32:0]        d_mag [3];
    logic               near_next;
    logic [45:0]        rq2_next;

    always_comb
    begin
        rq = {sphere[15:0], 8'h00};
        near_next = !rq[23] && (rq != 24'sd0);
        for (int k = 0; k < 3; k++)
        begin
            cen[k] = {sphere[63 - 16 * k -: 16], 8'h00};
            d_full[k] = $signed({in_part.pos[k][31], in_part.pos[k]})
                      - $signed({{9{cen[k][23]}}, cen[k]});
            d_mag[k] = d_full[k][32] ? 33'(-d_full[k]) : 33'(d_full[k]);
            if (d_mag[k] >= {9'd0, rq})
                near_next = 1'b0;
        end
        rq2_next = 46'(rq[22:0]) * 46'(rq[22:0]);
    end

    logic               c1_valid_reg;
    psb_pkg::particle_t c1_part_reg;
    logic signed [23:0] c1_d_reg [3];
    logic               c1_near_reg;
    logic [45:0]        c1_rq2_reg;

    // ---------------- stage 2: products ----------------
    logic [45:0]        dd_next [3];
    logic signed [55:0] dv_next [3];
    logic [40:0]        bd_next [3];
    logic [2:0]         dneg_next;
    logic signed [47:0] sq [3];
    logic [22:0]        dm [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sq[k] = c1_d_reg[k] * c1_d_reg[k];
            dd_next[k] = sq[k][45:0];
            dv_next[k] = c1_d_reg[k] * $signed(c1_part_reg.vel[k]);
            dm[k] = c1_d_reg[k][23] ? 23'(-c1_d_reg[k]) : c1_d_reg[k][22:0];
            bd_next[k] = 41'(bounce) * 41'(dm[k]);
            dneg_next[k] = c1_d_reg[k][23];
        end
    end

    logic               c2_valid_reg;
    psb_pkg::particle_t c2_part_reg;
    logic               c2_near_reg;
    logic [45:0]        c2_rq2_reg;
    logic [45:0]        c2_dd_reg [3];
    logic signed [55:0] c2_dv_reg [3];
    logic [40:0]        c2_bd_reg [3];
    logic [2:0]         c2_dneg_reg;

    // ---------------- stage 3: sums ----------------
    logic [47:0]        dist2_next;
    logic signed [57:0] dot_next;

    always_comb
    begin
        dist2_next = 48'(c2_dd_reg[0]) + 48'(c2_dd_reg[1]) + 48'(c2_dd_reg[2]);
        dot_next = 58'(c2_dv_reg[0]) + 58'(c2_dv_reg[1]) + 58'(c2_dv_reg[2]);
    end

    logic               c3_valid_reg;
    psb_pkg::particle_t c3_part_reg;
    logic               c3_near_reg;
    logic [45:0]        c3_rq2_reg;
    logic [47:0]        c3_dist2_reg;
    logic signed [57:0] c3_dot_reg;
    logic [40:0]        c3_bd_reg [3];
    logic [2:0]         c3_dneg_reg;

    // ---------------- stage 4: hit decision, dot magnitude ----------------
    logic        hit_next;
    logic [56:0] mdot_next;

    always_comb
    begin
        hit_next = c3_near_reg && (c3_dist2_reg < {2'b00, c3_rq2_reg}) && c3_dot_reg[57];
        mdot_next = c3_dot_reg[57] ? 57'(-c3_dot_reg) : c3_dot_reg[56:0];
    end

    logic               c4_valid_reg;
    psb_pkg::particle_t c4_part_reg;
    logic               c4_hit_reg;
    logic [47:0]        c4_dist2_reg;
    logic [56:0]        c4_mdot_reg;
    logic [40:0]        c4_bd_reg [3];
    logic [2:0]         c4_dneg_reg;

    // ---------------- stage 5: partial products ----------------
    logic [69:0] pl_next [3];
    logic [68:0] ph_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pl_next[k] = 70'(c4_bd_reg[k]) * 70'(c4_mdot_reg[28:0]);
            ph_next[k] = 69'(c4_bd_reg[k]) * 69'(c4_mdot_reg[56:29]);
        end
    end

    logic               c5_valid_reg;
    psb_pkg::particle_t c5_part_reg;
    logic               c5_hit_reg;
    logic [47:0]        c5_dist2_reg;
    logic [69:0]        c5_pl_reg [3];
    logic [68:0]        c5_ph_reg [3];
    logic [2:0]         c5_dneg_reg;

    // ---------------- stage 6: numerator ----------------
    logic [psb_pkg::NUM_W-1:0] num_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            num_next[k] = psb_pkg::NUM_W'(c5_pl_reg[k])
                        + (psb_pkg::NUM_W'(c5_ph_reg[k]) << 29);
    end

    logic                      c6_valid_reg;
    psb_pkg::particle_t        c6_part_reg;
    logic                      c6_hit_reg;
    logic [63:0]               c6_den_reg;
    logic [psb_pkg::NUM_W-1:0] c6_num_reg [3];
    logic [2:0]                c6_dneg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
            c3_valid_reg <= 1'b0;
            c4_valid_reg <= 1'b0;
            c5_valid_reg <= 1'b0;
            c6_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            c1_valid_reg <= in_valid;
            c2_valid_reg <= c1_valid_reg;
            c3_valid_reg <= c2_valid_reg;
            c4_valid_reg <= c3_valid_reg;
            c5_valid_reg <= c4_valid_reg;
            c6_valid_reg <= c5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            c1_part_reg <= in_part;
            c1_near_reg <= near_next;
            c1_rq2_reg  <= rq2_next;
            c2_part_reg <= c1_part_reg;
            c2_near_reg <= c1_near_reg;
            c2_rq2_reg  <= c1_rq2_reg;
            c2_dneg_reg <= dneg_next;
            c3_part_reg  <= c2_part_reg;
            c3_near_reg  <= c2_near_reg;
            c3_rq2_reg   <= c2_rq2_reg;
            c3_dist2_reg <= dist2_next;
            c3_dot_reg   <= dot_next;
            c3_dneg_reg  <= c2_dneg_reg;
            c4_part_reg  <= c3_part_reg;
            c4_hit_reg   <= hit_next;
            c4_dist2_reg <= c3_dist2_reg;
            c4_mdot_reg  <= mdot_next;
            c4_dneg_reg  <= c3_dneg_reg;
            c5_part_reg  <= c4_part_reg;
            c5_hit_reg   <= c4_hit_reg;
            c5_dist2_reg <= c4_dist2_reg;
            c5_dneg_reg  <= c4_dneg_reg;
            c6_part_reg  <= c5_part_reg;
            c6_hit_reg   <= c5_hit_reg;
            c6_den_reg   <= {c5_dist2_reg, 16'h0000};
            c6_dneg_reg  <= c5_dneg_reg;
            for (int k = 0; k < 3; k++)
            begin
                c1_d_reg[k]  <= d_full[k][23:0];
                c2_dd_reg[k] <= dd_next[k];
                c2_dv_reg[k] <= dv_next[k];
                c2_bd_reg[k] <= bd_next[k];
                c3_bd_reg[k] <= c2_bd_reg[k];
                c4_bd_reg[k] <= c3_bd_reg[k];
                c5_pl_reg[k] <= pl_next[k];
                c5_ph_reg[k] <= ph_next[k];
                c6_num_reg[k] <= num_next[k];
            end
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    // The quotient is known to fit when the sphere is hit; otherwise it is unused.
    logic                        dv_valid_reg [psb_pkg::QUOT_W];
    psb_pkg::particle_t          dv_part_reg  [psb_pkg::QUOT_W];
    logic                        dv_hit_reg   [psb_pkg::QUOT_W];
    logic [2:0]                  dv_dneg_reg  [psb_pkg::QUOT_W];
    logic [63:0]                 dv_den_reg   [psb_pkg::QUOT_W];
    logic [63:0]                 dv_rem_reg   [psb_pkg::QUOT_W][3];
    logic [psb_pkg::QUOT_W-1:0]  dv_low_reg   [psb_pkg::QUOT_W][3];
    logic [psb_pkg::QUOT_W-1:0]  dv_q_reg     [psb_pkg::QUOT_W][3];

    for (genvar s = 0; s < psb_pkg::QUOT_W; s++)
    begin : g_div
        logic                       valid_in;
        psb_pkg::particle_t         part_in;
        logic                       hit_in;
        logic [2:0]                 dneg_in;
        logic [63:0]                den_in;
        logic [63:0]                rem_in  [3];
        logic [psb_pkg::QUOT_W-1:0] low_in  [3];
        logic [psb_pkg::QUOT_W-1:0] q_in    [3];
        logic [64:0]                trial   [3];
        logic [64:0]                diff    [3];
        logic [63:0]                rem_next [3];
        logic [psb_pkg::QUOT_W-1:0] low_next [3];
        logic [psb_pkg::QUOT_W-1:0] q_next   [3];

        if (s == 0)
        begin : g_first
            always_comb
            begin
                valid_in = c6_valid_reg;
                part_in  = c6_part_reg;
                hit_in   = c6_hit_reg;
                dneg_in  = c6_dneg_reg;
                den_in   = c6_den_reg;
                for (int k = 0; k < 3; k++)
                begin
                    rem_in[k] = 64'(c6_num_reg[k] >> psb_pkg::QUOT_W);
                    low_in[k] = c6_num_reg[k][psb_pkg::QUOT_W-1:0];
                    q_in[k]   = '0;
                end
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                valid_in = dv_valid_reg[s-1];
                part_in  = dv_part_reg[s-1];
                hit_in   = dv_hit_reg[s-1];
                dneg_in  = dv_dneg_reg[s-1];
                den_in   = dv_den_reg[s-1];
                for (int k = 0; k < 3; k++)
                begin
                    rem_in[k] = dv_rem_reg[s-1][k];
                    low_in[k] = dv_low_reg[s-1][k];
                    q_in[k]   = dv_q_reg[s-1][k];
                end
            end
        end

        always_comb
        begin
            for (int k = 0; k < 3; k++)
            begin
                trial[k] = {rem_in[k], low_in[k][psb_pkg::QUOT_W-1]};
                diff[k]  = trial[k] - {1'b0, den_in};
                low_next[k] = {low_in[k][psb_pkg::QUOT_W-2:0], 1'b0};
                if (trial[k] >= {1'b0, den_in})
                begin
                    rem_next[k] = diff[k][63:0];
                    q_next[k]   = {q_in[k][psb_pkg::QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k] = trial[k][63:0];
                    q_next[k]   = {q_in[k][psb_pkg::QUOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[s] <= 1'b0;
            else if (ce)
                dv_valid_reg[s] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                dv_part_reg[s] <= part_in;
                dv_hit_reg[s]  <= hit_in;
                dv_dneg_reg[s] <= dneg_in;
                dv_den_reg[s]  <= den_in;
                for (int k = 0; k < 3; k++)
                begin
                    dv_rem_reg[s][k] <= rem_next[k];
                    dv_low_reg[s][k] <= low_next[k];
                    dv_q_reg[s][k]   <= q_next[k];
                end
            end
        end
    end

    // ---------------- stage 7: apply correction ----------------
    localparam int LAST = psb_pkg::QUOT_W - 1;

    psb_pkg::particle_t part_next;
    logic signed [39:0] vsum [3];
    logic signed [39:0] vext [3];
    logic signed [39:0] qext [3];

    always_comb
    begin
        part_next = dv_part_reg[LAST];
        for (int k = 0; k < 3; k++)
        begin
            vext[k] = {{8{dv_part_reg[LAST].vel[k][31]}}, dv_part_reg[LAST].vel[k]};
            qext[k] = $signed({{(40 - psb_pkg::QUOT_W){1'b0}}, dv_q_reg[LAST][k]});
            vsum[k] = dv_dneg_reg[LAST][k] ? vext[k] - qext[k] : vext[k] + qext[k];
            if (dv_hit_reg[LAST])
                part_next.vel[k] = psb_pkg::sat32(vsum[k]);
        end
    end

    logic               c7_valid_reg;
    psb_pkg::particle_t c7_part_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c7_valid_reg <= 1'b0;
        else if (ce)
            c7_valid_reg <= dv_valid_reg[LAST];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            c7_part_reg <= part_next;
    end

    assign out_valid = c7_valid_reg;
    assign out_part  = c7_part_reg;

endmodule

`default_nettype wire

// File: src/particle_sphere_bounce_euler_step_top.sv
// Top level of the particle step: configuration registers, sphere units,
// gravity and Euler integration, respawn and output skid. Needs psb_pkg, psb_collide.
//
//   Channel  | Signals                                      | Direction
//   s_axis   | s_axis_tvalid/tready, tdata[239:0]           | particle in
//   m_axis   | m_axis_tvalid/tready, tdata[191:0], tuser[0] | particle out
//   cfg      | cfg_valid/ready, cfg_index[2:0], cfg_data    | register write
//
// One particle beat is accepted per cycle while s_axis_tready is high. The path from input beat
// to output valid: input register, 42 stages per sphere unit (set by the 35-stage
// restoring divider), four integration stages and the output register.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// An output register plus a one-beat skid stage; s_axis_tready drops only while
// the skid stage holds a beat.
`default_nettype none

module particle_sphere_bounce_euler_step_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, rand_x, rand_y, rand_z
    input  wire logic [239:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
    output logic [191:0]      m_axis_tdata,
    // respawned
    output logic [0:0]        m_axis_tuser,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_data
);

    typedef struct packed {
        psb_pkg::particle_t part;
        logic               resp;
    } result_t;

    localparam int DLY = psb_pkg::NUM_SPHERES * psb_pkg::COL_LAT + 4;

    // ---------------- configuration ----------------
    logic [63:0] sphere_cfg_reg [psb_pkg::SPHERE_REGS];
    logic [15:0] ts_reg;
    logic [31:0] grav_reg;
    logic [17:0] bounce_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sphere_cfg_reg[0] <= psb_pkg::SPHERE_A_RST;
            sphere_cfg_reg[1] <= psb_pkg::SPHERE_B_RST;
            sphere_cfg_reg[2] <= psb_pkg::SPHERE_C_RST;
            ts_reg     <= psb_pkg::TIME_STEP_RST;
            grav_reg   <= psb_pkg::GRAVITY_Y_RST;
            bounce_reg <= psb_pkg::BOUNCE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                psb_pkg::REG_SPHERE_A:  sphere_cfg_reg[0] <= cfg_data;
                psb_pkg::REG_SPHERE_B:  sphere_cfg_reg[1] <= cfg_data;
                psb_pkg::REG_SPHERE_C:  sphere_cfg_reg[2] <= cfg_data;
                psb_pkg::REG_TIME_STEP: ts_reg     <= cfg_data[15:0];
                psb_pkg::REG_GRAVITY_Y: grav_reg   <= cfg_data[31:0];
                psb_pkg::REG_BOUNCE:    bounce_reg <= cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // ---------------- input stage ----------------
    logic ce;
    logic skid_valid_reg;

    assign ce = !skid_valid_reg;
    assign s_axis_tready = ce;

    logic               in_valid_reg;
    psb_pkg::particle_t in_part_reg;
    logic [47:0]        rnd_dly_reg [DLY];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (ce)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            in_part_reg.pos <= s_axis_tdata[95:0];
            in_part_reg.vel <= s_axis_tdata[191:96];
            rnd_dly_reg[0]  <= s_axis_tdata[239:192];
            for (int i = 1; i < DLY; i++)
                rnd_dly_reg[i] <= rnd_dly_reg[i-1];
        end
    end

    // ---------------- sphere chain ----------------
    logic               chain_valid [psb_pkg::NUM_SPHERES + 1];
    psb_pkg::particle_t chain_part  [psb_pkg::NUM_SPHERES + 1];

    assign chain_valid[0] = in_valid_reg;
    assign chain_part[0]  = in_part_reg;

    for (genvar j = 0; j < psb_pkg::NUM_SPHERES; j++)
    begin : g_sph
        psb_collide u_collide (
            .clk       (clk),
            .rst_n     (rst_n),
            .ce        (ce),
            .in_valid  (chain_valid[j]),
            .in_part   (chain_part[j]),
            .sphere    (sphere_cfg_reg[j]),
            .bounce    (bounce_reg),
            .out_valid (chain_valid[j+1]),
            .out_part  (chain_part[j+1])
        );
    end

    // ---------------- G1: gravity ----------------
    psb_pkg::particle_t col_part;
    psb_pkg::particle_t g1_part_next;
    logic signed [48:0] tsg;
    logic signed [39:0] vy_sum;

    assign col_part = chain_part[psb_pkg::NUM_SPHERES];

    always_comb
    begin
        tsg = $signed({1'b0, ts_reg}) * $signed(grav_reg);
        vy_sum = $signed({{8{col_part.vel[1][31]}}, col_part.vel[1]})
               + $signed({{7{tsg[48]}}, tsg[48:16]});
        g1_part_next = col_part;
        g1_part_next.vel[1] = psb_pkg::sat32(vy_sum);
    end

    logic               g1_valid_reg;
    psb_pkg::particle_t g1_part_reg;

    // ---------------- G2: step products ----------------
    logic signed [48:0] prod_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            prod_next[k] = $signed({1'b0, ts_reg}) * $signed(g1_part_reg.vel[k]);
    end

    logic               g2_valid_reg;
    psb_pkg::particle_t g2_part_reg;
    logic signed [48:0] g2_prod_reg [3];

    // ---------------- G3: position update ----------------
    psb_pkg::particle_t g3_part_next;
    logic signed [39:0] psum [3];
    logic               resp_next;

    always_comb
    begin
        g3_part_next = g2_part_reg;
        for (int k = 0; k < 3; k++)
        begin
            psum[k] = $signed({{8{g2_part_reg.pos[k][31]}}, g2_part_reg.pos[k]})
                    + $signed({{7{g2_prod_reg[k][48]}}, g2_prod_reg[k][48:16]});
            g3_part_next.pos[k] = psb_pkg::sat32(psum[k]);
        end
        resp_next = $signed(g3_part_next.pos[1]) < psb_pkg::FLOOR_Y;
    end

    logic               g3_valid_reg;
    psb_pkg::particle_t g3_part_reg;
    logic               g3_resp_reg;

    // ---------------- G4: respawn ----------------
    result_t            g4_next;
    logic [15:0]        rnd [3];
    logic signed [19:0] half_off [3];
    logic signed [22:0] spawn [3];

    always_comb
    begin
        g4_next.part = g3_part_reg;
        g4_next.resp = g3_resp_reg;
        for (int k = 0; k < 3; k++)
        begin
            rnd[k] = rnd_dly_reg[DLY-1][16 * k +: 16];
            half_off[k] = psb_pkg::HALF_Q16 - $signed({4'b0000, rnd[k]});
            spawn[k] = $signed({{3{half_off[k][19]}}, half_off[k]}) * 23'sd5;
            if (g3_resp_reg)
            begin
                g4_next.part.pos[k] = {{9{spawn[k][22]}}, spawn[k]};
                g4_next.part.vel[k] = '0;
            end
        end
        if (g3_resp_reg)
            g4_next.part.pos[1] = 32'($signed({{9{spawn[1][22]}}, spawn[1]}) + psb_pkg::SPAWN_Y);
    end

    logic    g4_valid_reg;
    result_t g4_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_valid_reg <= 1'b0;
            g2_valid_reg <= 1'b0;
            g3_valid_reg <= 1'b0;
            g4_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            g1_valid_reg <= chain_valid[psb_pkg::NUM_SPHERES];
            g2_valid_reg <= g1_valid_reg;
            g3_valid_reg <= g2_valid_reg;
            g4_valid_reg <= g3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            g1_part_reg <= g1_part_next;
            g2_part_reg <= g1_part_reg;
            for (int k = 0; k < 3; k++)
                g2_prod_reg[k] <= prod_next[k];
            g3_part_reg <= g3_part_next;
            g3_resp_reg <= resp_next;
            g4_data_reg <= g4_next;
        end
    end

    // ---------------- output register and skid ----------------
    // A beat leaving the pipeline always finds room: the pipeline only moves
    // while the skid stage is empty.
    logic    out_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= ce && g4_valid_reg;
            end
        end
        else if (ce && g4_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else
                out_data_reg <= g4_data_reg;
        end
        else if (ce)
        begin
            skid_data_reg <= g4_data_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg.part.vel, out_data_reg.part.pos};
    assign m_axis_tuser  = out_data_reg.resp;

`ifndef ASSERT_OFF
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a beat while the output register is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_axis_tready))
        else $error("skid stage filled without a stalled output beat");

    a_respawn_still: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.resp) |-> (out_data_reg.part.vel == '0))
        else $error("respawned particle carries nonzero velocity");
`endif

endmodule

`default_nettype wire

// File: tb/particle_sphere_bounce_euler_step_checker.sv
// Checker for the particle sphere bounce step: watches the register, input and output
// channels, predicts each output beat and compares it. Needs psb_pkg.
`timescale 1ns / 1ps

module particle_sphere_bounce_euler_step_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [239:0] s_axis_tdata,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [191:0] m_axis_tdata,
    input  wire logic [0:0]   m_axis_tuser,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_data,
    output int                errors,
    output int                pending
);

    logic [63:0] sphere_regs [3];
    logic [15:0] step_reg;
    logic [31:0] grav_reg;
    logic [17:0] bounce_reg;

    // Expected beats: respawned flag above the packed 192-bit particle.
    logic [192:0] particle_q [$];

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned magnitude(input longint x);
        return (x < 0) ? longint'(-x) : longint'(x);
    endfunction

    function automatic logic [192:0] step_particle(input logic [239:0] beat);
        longint p [3];
        longint v [3];
        longint c [3];
        longint d [3];
        longint rq, dist2, dot, delta, ts, g;
        logic [127:0] num, quot;
        logic [63:0] s;
        logic hit, resp;
        logic [191:0] outv;
        for (int k = 0; k < 3; k++)
        begin
            p[k] = longint'($signed(beat[32*k +: 32]));
            v[k] = longint'($signed(beat[96 + 32*k +: 32]));
        end
        for (int j = 0; j < psb_pkg::NUM_SPHERES; j++)
        begin
            s = sphere_regs[j];
            for (int k = 0; k < 3; k++)
                c[k] = longint'($signed(s[48 - 16*k +: 16])) * 256;
            rq = longint'($signed(s[15:0])) * 256;
            hit = (rq > 0);
            for (int k = 0; k < 3; k++)
            begin
                d[k] = p[k] - c[k];
                if (magnitude(d[k]) >= rq)
                    hit = 1'b0;
            end
            if (hit)
            begin
                dist2 = 0;
                dot = 0;
                for (int k = 0; k < 3; k++)
                begin
                    dist2 += d[k] * d[k];
                    dot += d[k] * v[k];
                end
                if (dist2 >= rq * rq || dot >= 0)
                    hit = 1'b0;
            end
            if (hit)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    num = 128'(bounce_reg) * 128'(magnitude(d[k])) * 128'(magnitude(dot));
                    quot = (num / 128'(dist2)) >> 16;
                    delta = longint'(quot[63:0]);
                    if ((d[k] < 0) != (dot < 0))
                        delta = -delta;
                    v[k] = clamp32(v[k] - delta);
                end
            end
        end
        ts = longint'({48'd0, step_reg});
        g = longint'($signed(grav_reg));
        v[1] = clamp32(v[1] + ((ts * g) >>> 16));
        for (int k = 0; k < 3; k++)
            p[k] = clamp32(p[k] + ((ts * v[k]) >>> 16));
        resp = (p[1] < longint'(psb_pkg::FLOOR_Y));
        if (resp)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p[k] = 5 * (longint'(psb_pkg::HALF_Q16)
                            - longint'({48'd0, beat[192 + 16*k +: 16]}));
                v[k] = 0;
            end
            p[1] += longint'(psb_pkg::SPAWN_Y);
        end
        for (int k = 0; k < 3; k++)
        begin
            outv[32*k +: 32] = p[k][31:0];
            outv[96 + 32*k +: 32] = v[k][31:0];
        end
        return {resp, outv};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [192:0] want;
        if (!rst_n)
        begin
            sphere_regs[0] = psb_pkg::SPHERE_A_RST;
            sphere_regs[1] = psb_pkg::SPHERE_B_RST;
            sphere_regs[2] = psb_pkg::SPHERE_C_RST;
            step_reg = psb_pkg::TIME_STEP_RST;
            grav_reg = psb_pkg::GRAVITY_Y_RST;
            bounce_reg = psb_pkg::BOUNCE_RST;
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    psb_pkg::REG_SPHERE_A:  sphere_regs[0] = cfg_data;
                    psb_pkg::REG_SPHERE_B:  sphere_regs[1] = cfg_data;
                    psb_pkg::REG_SPHERE_C:  sphere_regs[2] = cfg_data;
                    psb_pkg::REG_TIME_STEP: step_reg = cfg_data[15:0];
                    psb_pkg::REG_GRAVITY_Y: grav_reg = cfg_data[31:0];
                    psb_pkg::REG_BOUNCE:    bounce_reg = cfg_data[17:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                particle_q.push_back(step_particle(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (particle_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected output beat %h user %b", $time,
                             m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = particle_q.pop_front();
                    for (int k = 0; k < 6; k++)
                    begin
                        if (want[32*k +: 32] !== m_axis_tdata[32*k +: 32])
                        begin
                            errors++;
                            $display("%0t: field %0d expected %h actual %h", $time, k,
                                     want[32*k +: 32], m_axis_tdata[32*k +: 32]);
                        end
                    end
                    if (want[192] !== m_axis_tuser[0])
                    begin
                        errors++;
                        $display("%0t: respawned expected %b actual %b", $time,
                                 want[192], m_axis_tuser[0]);
                    end
                end
            end
            pending = particle_q.size();
        end
    end

endmodule

// File: tb/tb_particle_sphere_bounce_euler_step_top.sv
// Testbench top for the particle sphere bounce step: clock, reset, register writes,
// particle stimulus and output back-pressure. Needs psb_pkg, the block and its checker.
`timescale 1ns / 1ps

module tb_particle_sphere_bounce_euler_step_top;

    localparam int DRAIN_CYCLES = 140;
    localparam int CYCLE_LIMIT  = 800000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [239:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [191:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [63:0]  cfg_data;
    int           errors;
    int           pending;

    int           gap_pct;
    int           stall_pct;
    logic         hold_req;
    longint       cycles = 0;
    logic [63:0]  spheres [3];

    particle_sphere_bounce_euler_step_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    particle_sphere_bounce_euler_step_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_particle_sphere_bounce_euler_step_top: FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever hold_req toggles.
    always @(posedge clk)
    begin
        static logic seen_req = 1'b0;
        static int hold_cnt = 0;
        if (hold_req != seen_req)
        begin
            seen_req = hold_req;
            hold_cnt = 600;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Leaves cfg_valid high so that writes can follow back to back; the caller
    // drops it after the last write.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        if (idx <= psb_pkg::REG_SPHERE_C)
            spheres[idx] = value;
    endtask

    task automatic send_beat(input logic [239:0] beat);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= beat;
        s_axis_tvalid <= 1'b1;
        do @(negedge clk); while (!s_axis_tready);
        @(posedge clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [239:0] pack(input longint px, py, pz, vx, vy, vz,
                                          input logic [47:0] r);
        return {r, vz[31:0], vy[31:0], vx[31:0], pz[31:0], py[31:0], px[31:0]};
    endfunction

    // Most particles start inside a sphere heading inward, some fall toward the
    // floor, the rest are raw random bits.
    function automatic logic [239:0] make_particle();
        int sel, j, sh;
        longint rq, off [3], c [3], v [3];
        logic [47:0] r;
        sel = $urandom_range(0, 99);
        r = {$urandom(), $urandom()};
        j = $urandom_range(0, 2);
        rq = longint'($signed(spheres[j][15:0])) * 256;
        if (sel < 60 && rq > 0)
        begin
            sh = $urandom_range(0, 8);
            for (int k = 0; k < 3; k++)
            begin
                c[k] = longint'($signed(spheres[j][48 - 16*k +: 16])) * 256;
                off[k] = longint'($urandom_range(0, rq)) - rq / 2;
                v[k] = -((off[k] <<< sh) >>> 4) + longint'($urandom_range(0, 4095)) - 2048;
            end
            return pack(c[0] + off[0], c[1] + off[1], c[2] + off[2], v[0], v[1], v[2], r);
        end
        if (sel < 80)
            return pack($signed($urandom()) >>> 8,
                        -1966080 + longint'($urandom_range(0, 200000)) - 100000,
                        $signed($urandom()) >>> 8, $signed($urandom()) >>> 12,
                        -longint'($urandom_range(0, 8000000)),
                        $signed($urandom()) >>> 12, r);
        return {r, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    task automatic random_run(input int count);
        for (int i = 0; i < count; i++)
            send_beat(make_particle());
    endtask

    task automatic set_config(input logic [63:0] a, b, c, input logic [15:0] ts,
                              input logic [31:0] g, input logic [17:0] bf);
        write_reg(psb_pkg::REG_SPHERE_A, a);
        write_reg(psb_pkg::REG_SPHERE_B, b);
        write_reg(psb_pkg::REG_SPHERE_C, c);
        write_reg(psb_pkg::REG_TIME_STEP, {48'd0, ts});
        write_reg(psb_pkg::REG_GRAVITY_Y, {32'd0, g});
        write_reg(psb_pkg::REG_BOUNCE, {46'd0, bf});
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_req = 1'b0;
        gap_pct = 0;
        stall_pct = 0;
        spheres[0] = psb_pkg::SPHERE_A_RST;
        spheres[1] = psb_pkg::SPHERE_B_RST;
        spheres[2] = psb_pkg::SPHERE_C_RST;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats with the reset configuration.
        send_beat(pack(2147483647, 2147483647, 2147483647,
                       2147483647, 2147483647, 2147483647, 48'hFFFF_FFFF_FFFF));
        send_beat(pack(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                       -64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 48'h0));
        send_beat(pack(0, 12 * 65536, 65536, 1000, -5000, 3000, 48'h1234_5678_9ABC));
        send_beat(pack(65536, 13 * 65536, 65536, -100000, -100000, 0, 48'h0));
        send_beat(pack(-3 * 65536 + 200000, 100000, 0, -3000000, -2000000, 0, 48'h0));
        send_beat(pack(5 * 65536, -10 * 65536 + 300000, 0, 0, -4000000, 0, 48'h0));
        send_beat(pack(0, -1966080, 0, 0, 0, 0, 48'h0));
        send_beat(pack(0, -1966080, 0, 0, -10000000, 0, 48'hFFFF_FFFF_FFFF));
        send_beat(pack(0, -1966080, 0, 0, -10000000, 0, 48'h0000_8000_0000));
        send_beat(pack(0, -1966080 + 400, 0, 0, 0, 0, 48'h0));
        send_beat(pack(0, 0, 0, 0, 0, 0, 48'h0));
        random_run(250);
        wait_idle();

        // Extremes: longest step, strongest pulls, elastic bounce, radius max.
        set_config(64'h0000_0000_0000_7FFF, 64'hFF00_0100_0000_4000,
                   64'h0100_0000_FF00_2000, 16'hFFFF, 32'h8000_0000, 18'd131072);
        gap_pct = 73;
        stall_pct = 0;
        random_run(300);
        wait_idle();

        // Zero step, upward gravity, no bounce, two of the three spheres dead.
        set_config(64'h0100_0100_0100_0000, 64'h0000_0000_0000_8000,
                   64'h0000_0000_0000_0800, 16'h0000, 32'h7FFF_FFFF, 18'd0);
        gap_pct = 0;
        stall_pct = 73;
        random_run(250);
        wait_idle();

        // Random configuration, mild sizes; long hold-off fills the pipeline.
        set_config({16'($urandom_range(0, 65535) % 16'h0800 - 16'h0400), 16'h0000,
                    16'h0000, 16'h0A00},
                   {16'h0000, 16'hFE00, 16'h0200, 16'h0600},
                   {$urandom(), 16'h0000, 16'h1000},
                   16'($urandom_range(1, 4000)), -$urandom_range(0, 2000000),
                   18'($urandom_range(65536, 131072)));
        gap_pct = 0;
        stall_pct = 0;
        hold_req <= 1'b1;
        random_run(400);
        wait_idle();

        gap_pct = 18;
        stall_pct = 18;
        set_config(psb_pkg::SPHERE_A_RST, psb_pkg::SPHERE_B_RST, psb_pkg::SPHERE_C_RST,
                   psb_pkg::TIME_STEP_RST, psb_pkg::GRAVITY_Y_RST, 18'd65536);
        random_run(550);
        wait_idle();

        if (errors == 0)
            $display("tb_particle_sphere_bounce_euler_step_top: PASS");
        else
            $display("tb_particle_sphere_bounce_euler_step_top: FAIL");
        $finish;
    end

endmodule

// File: files.f
src/psb_pkg.sv
src/psb_collide.sv
src/particle_sphere_bounce_euler_step_top.sv
tb/particle_sphere_bounce_euler_step_checker.sv
tb/tb_particle_sphere_bounce_euler_step_top.sv
